// ===== rtl/sssp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sssp_pkg;

	localparam int VID_W  = 8;
	localparam int WT_W   = 16;
	localparam int DIST_W = 24;
	localparam int SUM_W  = DIST_W + 1;

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_SOLVE = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_RANGE    = 2'd1;
	localparam logic [1:0] ST_UNSOLVED = 2'd2;

	localparam logic [1:0] REG_SOURCE   = 2'd0;
	localparam logic [1:0] REG_VCOUNT   = 2'd1;
	localparam logic [1:0] REG_ECOUNT   = 2'd2;
	localparam logic [1:0] REG_INFINITY = 2'd3;

	// one edge on its way down the cell row
	typedef struct packed {
		logic              valid;
		logic              ok;
		logic [VID_W-1:0]  u;
		logic [VID_W-1:0]  t;
		logic [WT_W-1:0]   w;
		logic [SUM_W-1:0]  sum;
		logic              hit;
	} token_t;

	typedef struct packed {
		logic              init;
		logic              commit;
		logic              shift;
		logic [VID_W-1:0]  src;
		logic [8:0]        nv;
		logic [DIST_W-1:0] inf;
	} cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/sssp_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sssp_cell #(
	parameter int VERT = 0
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  sssp_pkg::cell_ctl_t                ctl,
	input  sssp_pkg::token_t                   tok_a_in,
	output sssp_pkg::token_t                   tok_a_out,
	input  sssp_pkg::token_t                   tok_b_in,
	output sssp_pkg::token_t                   tok_b_out,
	input  wire [sssp_pkg::DIST_W-1:0]         dist_in,
	output logic [sssp_pkg::DIST_W-1:0]        dist_out
);

	logic [sssp_pkg::DIST_W-1:0] dist_q;
	logic [sssp_pkg::DIST_W-1:0] pend_q;
	logic                        armed_q;
	sssp_pkg::token_t            tok_a_q;
	sssp_pkg::token_t            tok_b_q;
	logic                        is_src;
	logic                        a_hit;
	logic                        b_hit;
	logic [sssp_pkg::SUM_W-1:0]  sum_a;
	sssp_pkg::token_t            tok_a_nxt;
	sssp_pkg::token_t            tok_b_nxt;

	assign is_src = (32'(ctl.src) == VERT) && (VERT < 32'(ctl.nv));
	assign sum_a  = {1'b0, dist_q} + sssp_pkg::SUM_W'(tok_a_in.w);
	assign a_hit  = tok_a_in.valid && !tok_a_in.ok && (32'(tok_a_in.u) == VERT) && armed_q;
	assign b_hit  = tok_b_in.valid && tok_b_in.ok && (32'(tok_b_in.t) == VERT) &&
		(tok_b_in.sum < {1'b0, pend_q});

	always_comb begin
		tok_a_nxt = tok_a_in;
		if (a_hit) begin
			tok_a_nxt.sum = sum_a;
			tok_a_nxt.ok  = sum_a < {1'b0, ctl.inf};
		end
		tok_b_nxt = tok_b_in;
		if (b_hit) begin
			tok_b_nxt.hit = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_a_q <= '0;
			tok_b_q <= '0;
			armed_q <= 1'b0;
		end else begin
			tok_a_q <= tok_a_nxt;
			tok_b_q <= tok_b_nxt;
			if (ctl.init) begin
				armed_q <= is_src;
			end else if (ctl.commit) begin
				armed_q <= pend_q < dist_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			dist_q <= is_src ? '0 : ctl.inf;
			pend_q <= is_src ? '0 : ctl.inf;
		end else if (ctl.shift) begin
			dist_q <= dist_in;
		end else if (ctl.commit) begin
			if (pend_q < dist_q) begin
				dist_q <= pend_q;
			end
		end else if (b_hit) begin
			pend_q <= tok_b_in.sum[sssp_pkg::DIST_W-1:0];
		end
	end

	assign tok_a_out = tok_a_q;
	assign tok_b_out = tok_b_q;
	assign dist_out  = dist_q;

endmodule
`default_nettype wire

// ===== rtl/single_source_shortest_path.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shortest distances from one source over a stored edge list. After reset the edge store is
// cleared with busy high. Edge loads, reads and unused modes are taken one per cycle while busy
// is low, and each answers with a done strobe registered through p_valid_s1 and done_q; results
// cannot be held off. A solve holds busy high while it runs: a duplicate scan over the edge
// store through its two read ports, a step (S_INIT) to seed the cells, then rounds in which each
// edge walks the row of vertex cells twice (first to pick up its start distance, then to lower
// its end vertex), at most min(vertex_count, MAX_VERTICES) + 1 rounds and fewer once a round
// changes nothing, and finally a shift of the distances into the read memory. Its done strobe
// comes as busy falls.
module single_source_shortest_path #(
	parameter int MAX_VERTICES = 256,
	parameter int MAX_EDGES    = 256
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  mode,
	input  wire  [7:0]  edge_slot,
	input  wire  [7:0]  from_vertex,
	input  wire  [7:0]  to_vertex,
	input  wire  [15:0] weight_in,
	input  wire  [7:0]  query_vertex,
	input  wire         wr_en,
	input  wire  [1:0]  wr_index,
	input  wire  [23:0] wr_data,
	output logic        done,
	output logic [1:0]  status,
	output logic [23:0] distance,
	output logic        reachable
);

	localparam int EAW       = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW       = $clog2(MAX_EDGES + 1);
	localparam int VAW       = $clog2(MAX_VERTICES);
	localparam int DRAIN_LEN = 2 * MAX_VERTICES + 3;
	localparam int DW        = $clog2(DRAIN_LEN + 1);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_LIVE_K, S_LIVE_J, S_INIT, S_ROUND, S_DRAIN, S_COMMIT, S_UNLOAD
	} state_t;

	state_t state_q;

	logic [7:0]  src_q;
	logic [8:0]  vcount_q;
	logic [8:0]  ecount_q;
	logic [23:0] inf_q;

	logic [8:0]     nv;
	logic [ECW-1:0] ne;

	logic [15:0] pair_mem [MAX_EDGES];
	logic [15:0] wt_mem   [MAX_EDGES];
	logic        live_mem [MAX_EDGES];
	logic [23:0] dist_mem [MAX_VERTICES];

	logic [15:0] pair_rd_a;
	logic [15:0] pair_rd_b;
	logic [15:0] wt_rd_a;
	logic        live_rd_a;
	logic [23:0] dist_rd_q;

	logic [EAW-1:0] clr_q;
	logic [ECW-1:0] k_q;
	logic [ECW-1:0] j_q;
	logic           vb_s1;
	logic           dup_q;
	logic           iss_s1;
	logic [DW-1:0]  drain_q;
	logic [8:0]     round_q;
	logic [VAW-1:0] u_q;
	logic           changed_q;
	logic           solved_q;

	logic        p_valid_s1;
	logic        p_read_s1;
	logic [1:0]  p_status_s1;

	logic        done_q;
	logic [1:0]  status_q;
	logic [23:0] distance_q;
	logic        reachable_q;

	logic accept;
	logic load_we;
	logic clr_we;
	logic live_we;
	logic live_wd;

	sssp_pkg::cell_ctl_t ctl;
	sssp_pkg::token_t    tok_a [MAX_VERTICES+1];
	sssp_pkg::token_t    tok_b [MAX_VERTICES+1];
	logic [23:0]         dist_link [MAX_VERTICES+1];

	assign nv = (32'(vcount_q) > MAX_VERTICES) ? 9'(MAX_VERTICES) : vcount_q;
	assign ne = (32'(ecount_q) > MAX_EDGES) ? ECW'(MAX_EDGES) : ECW'(ecount_q);

	assign busy   = state_q != S_IDLE;
	assign accept = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q    <= 8'd0;
			vcount_q <= 9'd200;
			ecount_q <= 9'd0;
			inf_q    <= 24'd1000000;
		end else if (wr_en) begin
			unique case (wr_index)
				sssp_pkg::REG_SOURCE:   src_q    <= wr_data[7:0];
				sssp_pkg::REG_VCOUNT:   vcount_q <= wr_data[8:0];
				sssp_pkg::REG_ECOUNT:   ecount_q <= wr_data[8:0];
				sssp_pkg::REG_INFINITY: inf_q    <= wr_data;
				default: ;
			endcase
		end
	end

	assign load_we = accept && (mode == sssp_pkg::MODE_LOAD) && (32'(edge_slot) < MAX_EDGES);
	assign clr_we  = state_q == S_CLEAR;
	assign live_we = (state_q == S_LIVE_J) && (j_q == k_q) && !vb_s1;
	assign live_wd = !dup_q && (32'(pair_rd_a[15:8]) < 32'(nv)) &&
		(32'(pair_rd_a[7:0]) < 32'(nv)) && ({8'd0, wt_rd_a} < inf_q);

	// edge store: one write port, read at k and at j
	always_ff @(posedge clk) begin
		if (clr_we) begin
			pair_mem[clr_q] <= '0;
			wt_mem[clr_q]   <= '0;
		end else if (load_we) begin
			pair_mem[EAW'(edge_slot)] <= {from_vertex, to_vertex};
			wt_mem[EAW'(edge_slot)]   <= weight_in;
		end
		pair_rd_a <= pair_mem[k_q[EAW-1:0]];
		wt_rd_a   <= wt_mem[k_q[EAW-1:0]];
		pair_rd_b <= pair_mem[j_q[EAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (live_we) begin
			live_mem[k_q[EAW-1:0]] <= live_wd;
		end
		live_rd_a <= live_mem[k_q[EAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_UNLOAD) begin
			dist_mem[u_q] <= dist_link[0];
		end
		dist_rd_q <= dist_mem[VAW'(query_vertex)];
	end

	// cell row control
	assign ctl.init   = state_q == S_INIT;
	assign ctl.commit = state_q == S_COMMIT;
	assign ctl.shift  = state_q == S_UNLOAD;
	assign ctl.src    = src_q;
	assign ctl.nv     = nv;
	assign ctl.inf    = inf_q;

	always_comb begin
		tok_a[0]       = '0;
		tok_a[0].valid = iss_s1 && live_rd_a;
		tok_a[0].u     = pair_rd_a[15:8];
		tok_a[0].t     = pair_rd_a[7:0];
		tok_a[0].w     = wt_rd_a;
	end
	// second walk starts where the first one ends
	assign tok_b[0]                = tok_a[MAX_VERTICES];
	assign dist_link[MAX_VERTICES] = inf_q;

	for (genvar v = 0; v < MAX_VERTICES; v++) begin : g_cell
		sssp_cell #(.VERT(v)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.tok_a_in  (tok_a[v]),
			.tok_a_out (tok_a[v+1]),
			.tok_b_in  (tok_b[v]),
			.tok_b_out (tok_b[v+1]),
			.dist_in   (dist_link[v+1]),
			.dist_out  (dist_link[v])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			k_q         <= '0;
			j_q         <= '0;
			vb_s1       <= 1'b0;
			dup_q       <= 1'b0;
			iss_s1      <= 1'b0;
			drain_q     <= '0;
			round_q     <= '0;
			u_q         <= '0;
			changed_q   <= 1'b0;
			solved_q    <= 1'b0;
			p_valid_s1  <= 1'b0;
			p_read_s1   <= 1'b0;
			p_status_s1 <= sssp_pkg::ST_OK;
			done_q      <= 1'b0;
			status_q    <= sssp_pkg::ST_OK;
			distance_q  <= '0;
			reachable_q <= 1'b0;
		end else begin
			iss_s1      <= 1'b0;
			vb_s1       <= 1'b0;
			p_valid_s1  <= 1'b0;
			done_q      <= p_valid_s1;
			status_q    <= p_status_s1;
			distance_q  <= (p_read_s1 && p_status_s1 == sssp_pkg::ST_OK) ? dist_rd_q : '0;
			reachable_q <= p_read_s1 && p_status_s1 == sssp_pkg::ST_OK && dist_rd_q < inf_q;
			if (tok_b[MAX_VERTICES].valid && tok_b[MAX_VERTICES].hit) begin
				changed_q <= 1'b1;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == MAX_EDGES - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (mode == sssp_pkg::MODE_SOLVE) begin
							state_q <= S_LIVE_K;
							k_q     <= '0;
						end else begin
							p_valid_s1  <= 1'b1;
							p_read_s1   <= mode == sssp_pkg::MODE_READ;
							p_status_s1 <= sssp_pkg::ST_OK;
							if (mode == sssp_pkg::MODE_LOAD) begin
								solved_q <= 1'b0;
							end
							if (mode == sssp_pkg::MODE_READ) begin
								if (!solved_q) begin
									p_status_s1 <= sssp_pkg::ST_UNSOLVED;
								end else if ({1'b0, query_vertex} >= nv) begin
									p_status_s1 <= sssp_pkg::ST_RANGE;
								end
							end
						end
					end
				end
				S_LIVE_K: begin
					if (k_q == ne) begin
						state_q <= S_INIT;
					end else begin
						j_q     <= '0;
						dup_q   <= 1'b0;
						state_q <= S_LIVE_J;
					end
				end
				S_LIVE_J: begin
					if (vb_s1 && pair_rd_b == pair_rd_a) begin
						dup_q <= 1'b1;
					end
					if (j_q < k_q) begin
						vb_s1 <= 1'b1;
						j_q   <= j_q + 1'b1;
					end else if (!vb_s1) begin
						k_q     <= k_q + 1'b1;
						state_q <= S_LIVE_K;
					end
				end
				S_INIT: begin
					k_q       <= '0;
					round_q   <= '0;
					changed_q <= 1'b0;
					state_q   <= S_ROUND;
				end
				S_ROUND: begin
					if (k_q < ne) begin
						iss_s1 <= 1'b1;
						k_q    <= k_q + 1'b1;
					end else begin
						drain_q <= '0;
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (32'(drain_q) == DRAIN_LEN - 1) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					if (!changed_q || round_q == nv) begin
						u_q     <= '0;
						state_q <= S_UNLOAD;
					end else begin
						round_q   <= round_q + 1'b1;
						changed_q <= 1'b0;
						k_q       <= '0;
						state_q   <= S_ROUND;
					end
				end
				S_UNLOAD: begin
					u_q <= u_q + 1'b1;
					if (u_q == VAW'(MAX_VERTICES - 1)) begin
						state_q     <= S_IDLE;
						solved_q    <= 1'b1;
						done_q      <= 1'b1;
						status_q    <= sssp_pkg::ST_OK;
						distance_q  <= '0;
						reachable_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign distance  = distance_q;
	assign reachable = reachable_q;

	// a solve transaction holds the port
	a_solve_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode == sssp_pkg::MODE_SOLVE) |=> busy)
		else $error("solve accepted without going busy");

	// every edge has left the row before the round is committed
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMMIT) |-> (!tok_b[MAX_VERTICES].valid && !iss_s1))
		else $error("round committed with edges still in the cell row");

	a_solved_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(solved_q) |-> (done && status == sssp_pkg::ST_OK))
		else $error("solve finished without a result strobe");

endmodule
`default_nettype wire

// ===== dv/tb_single_source_shortest_path.sv =====
`timescale 1ns / 1ps
module tb_single_source_shortest_path;

	localparam logic [1:0] MODE_IDLE = 2'd3;
	localparam int NV_MAX = 256;
	localparam int NE_MAX = 256;
	localparam int QUIET_LIMIT = 1000000;

	typedef enum {STEP_ITEM, STEP_CFG, STEP_DRAIN} step_kind_t;

	typedef struct {
		step_kind_t  kind;
		logic [1:0]  mode;
		logic [7:0]  slot;
		logic [7:0]  src_v;
		logic [7:0]  dst_v;
		logic [15:0] wt;
		logic [7:0]  query;
		logic [1:0]  reg_idx;
		logic [23:0] reg_val;
	} step_t;

	typedef struct {
		logic [1:0]  status;
		logic [23:0] dist_val;
		logic        reach;
	} answer_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  mode;
	logic [7:0]  edge_slot;
	logic [7:0]  from_vertex;
	logic [7:0]  to_vertex;
	logic [15:0] weight_in;
	logic [7:0]  query_vertex;
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [23:0] wr_data;
	logic        done;
	logic [1:0]  status;
	logic [23:0] distance;
	logic        reachable;

	single_source_shortest_path DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.edge_slot(edge_slot), .from_vertex(from_vertex), .to_vertex(to_vertex),
		.weight_in(weight_in), .query_vertex(query_vertex), .wr_en(wr_en),
		.wr_index(wr_index), .wr_data(wr_data), .done(done), .status(status),
		.distance(distance), .reachable(reachable)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// shadow of the block
	logic [7:0]  sh_source;
	logic [8:0]  sh_vcount;
	logic [8:0]  sh_ecount;
	logic [23:0] sh_inf;
	logic [7:0]  sh_from [NE_MAX];
	logic [7:0]  sh_to   [NE_MAX];
	logic [15:0] sh_wt   [NE_MAX];
	logic [23:0] sh_dist [NV_MAX];
	logic        sh_solved;

	step_t   pending_q[$];
	answer_t answer_q[$];

	int errors;
	int n_items;
	int n_solves;
	int n_reach;
	int n_answers;
	int gap_left;
	int burst_left;
	int settle_cnt;
	int quiet_cnt;
	logic nxt_start;
	logic nxt_wr;

	function automatic void solve_distances();
		int nv, ne, inf, u, t, s;
		bit live [NE_MAX];
		bit settled [NV_MAX];
		int pend [NV_MAX];
		int cur [NV_MAX];
		bit changed;
		nv = (int'(sh_vcount) > NV_MAX) ? NV_MAX : int'(sh_vcount);
		ne = (int'(sh_ecount) > NE_MAX) ? NE_MAX : int'(sh_ecount);
		inf = int'(sh_inf);
		for (int k = 0; k < NE_MAX; k++) begin
			live[k] = 1'b0;
			if (k < ne) begin
				bit first;
				first = 1'b1;
				for (int j = 0; j < k; j++)
					if (sh_from[j] == sh_from[k] && sh_to[j] == sh_to[k])
						first = 1'b0;
				if (first && int'(sh_from[k]) < nv && int'(sh_to[k]) < nv &&
						int'(sh_wt[k]) < inf)
					live[k] = 1'b1;
			end
		end
		for (int v = 0; v < NV_MAX; v++) begin
			cur[v] = inf;
			settled[v] = (v >= nv);
		end
		for (int k = 0; k < ne; k++)
			if (live[k] && sh_from[k] == sh_source && sh_to[k] != sh_source)
				cur[sh_to[k]] = int'(sh_wt[k]);
		if (int'(sh_source) < nv) begin
			cur[sh_source] = 0;
			settled[sh_source] = 1'b1;
		end
		for (int v = 0; v < NV_MAX; v++)
			pend[v] = cur[v];
		for (int r = 0; r < nv; r++) begin
			changed = 1'b0;
			for (int k = 0; k < ne; k++) begin
				if (live[k]) begin
					u = int'(sh_from[k]);
					t = int'(sh_to[k]);
					if (!settled[u]) begin
						s = cur[u] + int'(sh_wt[k]);
						if (s < inf && s < pend[t])
							pend[t] = s;
					end
				end
			end
			for (int v = 0; v < nv; v++)
				settled[v] = 1'b1;
			for (int v = 0; v < nv; v++) begin
				if (pend[v] < cur[v]) begin
					cur[v] = pend[v];
					settled[v] = 1'b0;
					changed = 1'b1;
				end
				pend[v] = cur[v];
			end
			if (!changed)
				break;
		end
		for (int v = 0; v < NV_MAX; v++)
			sh_dist[v] = 24'(cur[v]);
		sh_solved = 1'b1;
	endfunction

	function automatic answer_t predict_answer(step_t it);
		answer_t a;
		int nv;
		a = '{sssp_pkg::ST_OK, 24'd0, 1'b0};
		nv = (int'(sh_vcount) > NV_MAX) ? NV_MAX : int'(sh_vcount);
		case (it.mode)
			sssp_pkg::MODE_LOAD: begin
				sh_from[it.slot] = it.src_v;
				sh_to[it.slot] = it.dst_v;
				sh_wt[it.slot] = it.wt;
				sh_solved = 1'b0;
			end
			sssp_pkg::MODE_SOLVE: begin
				solve_distances();
				n_solves++;
			end
			sssp_pkg::MODE_READ: begin
				if (!sh_solved)
					a.status = sssp_pkg::ST_UNSOLVED;
				else if (int'(it.query) >= nv)
					a.status = sssp_pkg::ST_RANGE;
				else begin
					a.dist_val = sh_dist[it.query];
					a.reach = (a.dist_val < sh_inf);
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	function automatic void apply_reg(logic [1:0] idx, logic [23:0] val);
		case (idx)
			sssp_pkg::REG_SOURCE:   sh_source = val[7:0];
			sssp_pkg::REG_VCOUNT:   sh_vcount = val[8:0];
			sssp_pkg::REG_ECOUNT:   sh_ecount = val[8:0];
			sssp_pkg::REG_INFINITY: sh_inf = val;
			default: ;
		endcase
	endfunction

	task automatic add_item(logic [1:0] m, logic [7:0] s, logic [7:0] f, logic [7:0] t,
			logic [15:0] w, logic [7:0] q);
		step_t st;
		st = '{STEP_ITEM, m, s, f, t, w, q, sssp_pkg::REG_SOURCE, 24'd0};
		pending_q.push_back(st);
	endtask

	task automatic add_load(logic [7:0] s, logic [7:0] f, logic [7:0] t, logic [15:0] w);
		add_item(sssp_pkg::MODE_LOAD, s, f, t, w, 8'($urandom_range(0, 255)));
	endtask

	task automatic add_solve();
		add_item(sssp_pkg::MODE_SOLVE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
			8'($urandom_range(0, 255)));
	endtask

	task automatic add_read(logic [7:0] q);
		add_item(sssp_pkg::MODE_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), q);
	endtask

	task automatic add_reg(logic [1:0] idx, logic [23:0] val);
		step_t st;
		st = '{STEP_CFG, sssp_pkg::MODE_LOAD, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, idx, val};
		pending_q.push_back(st);
	endtask

	task automatic add_drain();
		step_t st;
		st = '{STEP_DRAIN, sssp_pkg::MODE_LOAD, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0,
			sssp_pkg::REG_SOURCE, 24'd0};
		pending_q.push_back(st);
	endtask

	task automatic add_setting(int src, int nv, int ne, int inf);
		add_reg(sssp_pkg::REG_SOURCE, 24'(src));
		add_reg(sssp_pkg::REG_VCOUNT, 24'(nv));
		add_reg(sssp_pkg::REG_ECOUNT, 24'(ne));
		add_reg(sssp_pkg::REG_INFINITY, 24'(inf));
	endtask

	function automatic logic [7:0] pick_vertex(int nv);
		if (nv == 0 || $urandom_range(0, 9) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, (nv > NV_MAX ? NV_MAX : nv) - 1));
	endfunction

	task automatic random_phase(bit big);
		int nv, ne, inf, nload, nread, r;
		r = $urandom_range(0, 9);
		if (big)
			nv = 511;
		else if (r == 0)
			nv = 0;
		else if (r == 1)
			nv = 256;
		else
			nv = $urandom_range(2, 24);
		if (big)
			ne = 511;
		else if (nv == 256)
			ne = $urandom_range(0, 40);
		else
			ne = $urandom_range(0, (2 * nv > 40) ? 40 : 2 * nv);
		r = $urandom_range(0, 5);
		case (r)
			0: inf = $urandom_range(1, 4);
			1: inf = 24'hffffff;
			2: inf = $urandom_range(1, 24'hffffff);
			3: inf = $urandom_range(1, 65535);
			default: inf = $urandom_range(50, 400);
		endcase
		add_setting(($urandom_range(0, 4) == 0 || nv == 0) ? $urandom_range(0, 255)
			: $urandom_range(0, (nv > NV_MAX ? NV_MAX : nv) - 1), nv, ne, inf);
		nload = big ? 20 : ((ne > 40) ? 40 : ne);
		for (int k = 0; k < nload; k++)
			add_load(8'((big || $urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : k),
				pick_vertex(nv), pick_vertex(nv),
				16'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
					: $urandom_range(0, 60)));
		add_solve();
		nread = $urandom_range(14, 24);
		for (int k = 0; k < nread; k++) begin
			r = $urandom_range(0, 29);
			if (r == 0)
				add_item(MODE_IDLE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
					8'($urandom_range(0, 255)));
			else if (r == 1) begin
				// a late load drops the solution until the next solve
				add_load(8'($urandom_range(0, 255)), pick_vertex(nv), pick_vertex(nv),
					16'($urandom_range(0, 65535)));
				add_read(pick_vertex(nv));
				add_solve();
			end else if (r == 2)
				add_drain();
			else
				add_read(pick_vertex(nv));
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			nxt_start = start;
			nxt_wr = 1'b0;
			if (start && !busy) begin
				answer_q.push_back(predict_answer(pending_q[0]));
				pending_q.pop_front();
				n_items++;
				nxt_start = 1'b0;
				if (burst_left > 0) begin
					burst_left--;
					gap_left = 0;
				end else if ($urandom_range(0, 15) == 0) begin
					burst_left = $urandom_range(10, 40);
					gap_left = 0;
				end else
					gap_left = $urandom_range(0, 14);
			end
			if (!nxt_start && pending_q.size() > 0) begin
				if (gap_left > 0)
					gap_left--;
				else begin
					case (pending_q[0].kind)
						STEP_ITEM: begin
							mode <= pending_q[0].mode;
							edge_slot <= pending_q[0].slot;
							from_vertex <= pending_q[0].src_v;
							to_vertex <= pending_q[0].dst_v;
							weight_in <= pending_q[0].wt;
							query_vertex <= pending_q[0].query;
							nxt_start = 1'b1;
						end
						STEP_CFG: begin
							if (answer_q.size() == 0 && settle_cnt >= 8) begin
								nxt_wr = 1'b1;
								wr_index <= pending_q[0].reg_idx;
								wr_data <= pending_q[0].reg_val;
								apply_reg(pending_q[0].reg_idx, pending_q[0].reg_val);
								pending_q.pop_front();
							end
						end
						default: begin
							if (answer_q.size() == 0)
								pending_q.pop_front();
						end
					endcase
				end
			end
			wr_en <= nxt_wr;
			start <= nxt_start;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || start || busy || answer_q.size() != 0)
			settle_cnt <= 0;
		else
			settle_cnt <= settle_cnt + 1;
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			answer_t exp_a;
			if (answer_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected transaction status=%0d distance=%0d reachable=%0d",
					$time, status, distance, reachable);
			end else begin
				exp_a = answer_q.pop_front();
				n_answers++;
				if (exp_a.reach)
					n_reach++;
				if (status !== exp_a.status) begin
					errors++;
					$display("%0t: status expected %0d actual %0d", $time, exp_a.status, status);
				end
				if (distance !== exp_a.dist_val) begin
					errors++;
					$display("%0t: distance expected %0d actual %0d", $time, exp_a.dist_val,
						distance);
				end
				if (reachable !== exp_a.reach) begin
					errors++;
					$display("%0t: reachable expected %0d actual %0d", $time, exp_a.reach,
						reachable);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cnt <= 0;
			else
				quiet_cnt <= quiet_cnt + 1;
			if (quiet_cnt >= QUIET_LIMIT) begin
				$display("single_source_shortest_path: mismatch");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		mode = sssp_pkg::MODE_LOAD;
		edge_slot = 8'd0;
		from_vertex = 8'd0;
		to_vertex = 8'd0;
		weight_in = 16'd0;
		query_vertex = 8'd0;
		wr_en = 1'b0;
		wr_index = sssp_pkg::REG_SOURCE;
		wr_data = 24'd0;
		errors = 0;
		n_items = 0;
		n_solves = 0;
		n_reach = 0;
		n_answers = 0;
		gap_left = 0;
		burst_left = 0;
		quiet_cnt = 0;
		sh_source = 8'd0;
		sh_vcount = 9'd200;
		sh_ecount = 9'd0;
		sh_inf = 24'd1000000;
		sh_solved = 1'b0;
		for (int k = 0; k < NE_MAX; k++) begin
			sh_from[k] = 8'd0;
			sh_to[k] = 8'd0;
			sh_wt[k] = 16'd0;
		end

		// reset config: read before solve, unused mode, extreme loads
		add_read(8'd0);
		add_item(MODE_IDLE, 8'hff, 8'hff, 8'hff, 16'hffff, 8'hff);
		add_load(8'd255, 8'hff, 8'hff, 16'hffff);
		add_load(8'd0, 8'd0, 8'd0, 16'd0);
		add_solve();
		add_read(8'd0);
		add_read(8'd199);
		add_read(8'd200);
		add_read(8'd255);
		// duplicate pair, weight at infinity, out of range end, sum equal to infinity
		add_setting(1, 5, 6, 100);
		add_load(8'd0, 8'd1, 8'd2, 16'd5);
		add_load(8'd1, 8'd2, 8'd3, 16'd7);
		add_load(8'd2, 8'd1, 8'd2, 16'd1);
		add_load(8'd3, 8'd1, 8'd4, 16'd100);
		add_load(8'd4, 8'd3, 8'd9, 16'd1);
		add_load(8'd5, 8'd2, 8'd4, 16'd95);
		add_solve();
		for (int q = 0; q < 6; q++)
			add_read(8'(q));
		add_reg(sssp_pkg::REG_INFINITY, 24'd6);
		add_read(8'd2);
		add_read(8'd4);
		// zero vertices, then source out of range
		add_setting(0, 0, 6, 24'hffffff);
		add_solve();
		add_read(8'd0);
		add_setting(7, 5, 6, 100);
		add_solve();
		add_read(8'd1);
		add_drain();

		for (int p = 0; p < 21; p++)
			random_phase(p == 8);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_q.size() != 0 || answer_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		$display("%0d transactions, %0d solves, %0d results checked, %0d reachable reads",
			n_items, n_solves, n_answers, n_reach);
		if (errors == 0 && answer_q.size() == 0)
			$display("single_source_shortest_path: match");
		else
			$display("single_source_shortest_path: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/sssp_pkg.sv
rtl/sssp_cell.sv
rtl/single_source_shortest_path.sv
dv/tb_single_source_shortest_path.sv
